FILE: design/amt_pkg.sv
// Shared types and constants for the address to MAC table.
// No dependencies.
package amt_pkg;

  localparam int TableEntries = 16;
  localparam int CountW       = $clog2(TableEntries + 1);
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int AddrW        = 16;
  localparam int MacW         = 48;

  localparam logic [MacW-1:0] BroadcastMac = {MacW{1'b1}};

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_LEARN  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [AddrW-1:0] addr;
    logic [MacW-1:0]  mac;
  } item_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [MacW-1:0]  mac;
  } wr_t;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [MacW-1:0]   mac;
    logic [CountW-1:0] count;
  } match_t;

endpackage

FILE: design/amt_table.sv
// Entry storage, fill count and parallel address compare.
// Depends on amt_pkg.
module amt_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  amt_pkg::wr_t                wr,
  input  logic [amt_pkg::AddrW-1:0]   lookup_addr,
  output amt_pkg::match_t             match
);

  logic [amt_pkg::AddrW-1:0]  addr_r [amt_pkg::TableEntries];
  logic [amt_pkg::MacW-1:0]   mac_r  [amt_pkg::TableEntries];
  logic [amt_pkg::CountW-1:0] count_r;
  logic [amt_pkg::CountW-1:0] count_nxt;
  logic [amt_pkg::TableEntries-1:0] hit_vec;
  logic [amt_pkg::MacW-1:0]   mac_sel;

  // entries fill in order, so entry i is in use when i < count
  always_comb begin
    mac_sel = '0;
    for (int i = 0; i < amt_pkg::TableEntries; i++) begin
      hit_vec[i] = (amt_pkg::CountW'(i) < count_r) && (addr_r[i] == lookup_addr);
      if (hit_vec[i]) begin
        mac_sel = mac_sel | mac_r[i];
      end
    end
  end

  assign count_nxt   = count_r + amt_pkg::CountW'(1);
  assign match.hit   = |hit_vec;
  assign match.full  = (count_r == amt_pkg::CountW'(amt_pkg::TableEntries));
  assign match.mac   = mac_sel;
  assign match.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr.en) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      addr_r[count_r[amt_pkg::IdxW-1:0]] <= wr.addr;
      mac_r[count_r[amt_pkg::IdxW-1:0]]  <= wr.mac;
    end
  end

endmodule

FILE: design/address_to_mac_table_unit.sv
// Top level of the address to MAC table: input register, decision logic, result register.
// Depends on amt_pkg and amt_table.

// Maps a 16-bit node address to a 48-bit MAC. A learn word (tuser = 1) stores the pair in
// the next free entry unless the address is already held; a lookup word (tuser = 0) returns
// the stored MAC or all ones on a miss. Status on out_tuser: 0 hit/added, 1 miss, 2 already
// present, 3 table full and learn dropped. One word is taken per cycle while the result
// register can advance (empty or out_tready high); its result word passes from the input
// register to the result register. All entries are compared in parallel, combinationally,
// between the input and result registers. Reset empties the table at once.
module address_to_mac_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // node_address[15:0], mac_value[63:16]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // mac_result[47:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  logic                     s1_valid_r;
  amt_pkg::item_t           s1_item_r;
  logic                     out_valid_r;
  logic [amt_pkg::MacW-1:0] out_mac_r;
  amt_pkg::status_t         out_status_r;

  logic                     advance;
  logic                     in_acc;
  logic [amt_pkg::MacW-1:0] mac_nxt;
  amt_pkg::status_t         status_nxt;
  amt_pkg::wr_t             wr;
  amt_pkg::match_t          match;

  amt_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .lookup_addr (s1_item_r.addr),
    .match       (match)
  );

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    mac_nxt    = '0;
    status_nxt = amt_pkg::ST_OK;
    wr.en      = 1'b0;
    wr.addr    = s1_item_r.addr;
    wr.mac     = s1_item_r.mac;
    case (s1_item_r.op)
      amt_pkg::OP_LOOKUP: begin
        if (match.hit) begin
          mac_nxt = match.mac;
        end else begin
          mac_nxt    = amt_pkg::BroadcastMac;
          status_nxt = amt_pkg::ST_MISS;
        end
      end
      amt_pkg::OP_LEARN: begin
        if (match.hit) begin
          status_nxt = amt_pkg::ST_PRESENT;
        end else if (match.full) begin
          status_nxt = amt_pkg::ST_FULL;
        end else begin
          wr.en = s1_valid_r && advance;
        end
      end
      default: begin
        status_nxt = amt_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op   <= amt_pkg::op_t'(in_tuser[0]);
      s1_item_r.addr <= in_tdata[15:0];
      s1_item_r.mac  <= in_tdata[63:16];
    end
    if (advance && s1_valid_r) begin
      out_mac_r    <= mac_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mac_r;
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match.count <= amt_pkg::CountW'(amt_pkg::TableEntries))
    else $error("fill count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> match.count == $past(match.count) + amt_pkg::CountW'(1))
    else $error("learn did not advance fill count");

  a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == amt_pkg::ST_FULL) |-> match.full)
    else $error("full status with free entries");

  a_miss_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == amt_pkg::ST_MISS) |-> out_tdata == amt_pkg::BroadcastMac)
    else $error("miss without broadcast MAC");

endmodule
